// ===== rtl/core/efo_pkg.sv =====
// Shared constants, codes and control structs of the event fan-out block.
package efo_pkg;

    localparam int NUM_EVENTS = 128;
    localparam int NUM_TASKS  = 32;

    localparam int KIND_W   = 2;
    localparam int EV_W     = 8;
    localparam int EV_AW    = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int TASK_W   = 5;
    localparam int MASK_W   = 32;
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int DEV_W    = 7;
    localparam int MODE_W   = 2;
    localparam int CNT_W    = 32;

    localparam logic [EV_W:0]   EV_LIMIT   = (EV_W + 1)'(NUM_EVENTS);
    localparam logic [TASK_W:0] TASK_LIMIT = (TASK_W + 1)'(NUM_TASKS);

    localparam logic [KIND_W-1:0] KIND_SUB   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNSUB = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PUB   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ORIGINAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COPY     = 2'd2;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [MASK_W-1:0] mask;
    } t_scan_ctl;

    typedef struct packed {
        logic              hit;
        logic              last;
        logic              first;
        logic [TASK_W-1:0] tsk;
    } t_scan_st;

endpackage

// ===== rtl/core/efo_if.sv =====
// Request and delivery channel interfaces of the event fan-out block.
interface efo_req_if;
    logic                         valid;
    logic                         ready;
    logic [efo_pkg::KIND_W-1:0]   kind;
    logic [efo_pkg::EV_W-1:0]     event_id;
    logic [efo_pkg::TASK_W-1:0]   task_index;
    logic [efo_pkg::HANDLE_W-1:0] payload_handle;
    logic [efo_pkg::SIZE_W-1:0]   payload_size;
    logic                         single_handoff;

    modport source (output valid, kind, event_id, task_index, payload_handle,
                    payload_size, single_handoff, input ready);
    modport sink   (input valid, kind, event_id, task_index, payload_handle,
                    payload_size, single_handoff, output ready);
endinterface

interface efo_dlv_if;
    logic                         valid;
    logic                         ready;
    logic [efo_pkg::TASK_W-1:0]   target_task;
    logic [efo_pkg::DEV_W-1:0]    delivered_event;
    logic [efo_pkg::HANDLE_W-1:0] handed_payload;
    logic [efo_pkg::SIZE_W-1:0]   handed_size;
    logic [efo_pkg::MODE_W-1:0]   delivery_mode;
    logic                         is_last;
    logic [efo_pkg::CNT_W-1:0]    published_total;
    logic [efo_pkg::CNT_W-1:0]    dropped_total;

    modport source (output valid, target_task, delivered_event, handed_payload,
                    handed_size, delivery_mode, is_last, published_total,
                    dropped_total, input ready);
    modport sink   (input valid, target_task, delivered_event, handed_payload,
                    handed_size, delivery_mode, is_last, published_total,
                    dropped_total, output ready);
endinterface

// ===== rtl/core/efo_mask_table.sv =====
// Subscriber mask memory with per-entry valid bits and a registered read port.
module efo_mask_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [efo_pkg::EV_AW-1:0]   i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [efo_pkg::EV_AW-1:0]   i_wr_addr,
    input  logic [efo_pkg::MASK_W-1:0]  i_wr_data,
    output logic [efo_pkg::MASK_W-1:0]  o_rd_data
);

    logic [efo_pkg::MASK_W-1:0]     r_mem [efo_pkg::NUM_EVENTS];
    logic [efo_pkg::NUM_EVENTS-1:0] r_valid;
    logic [efo_pkg::MASK_W-1:0]     r_rd_data;
    logic                           r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // an entry never written since reset reads as an empty mask
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== rtl/core/efo_scan_unit.sv =====
// Bit-serial subscriber scanner: one task bit examined per step.
module efo_scan_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  efo_pkg::t_scan_ctl i_ctl,
    output efo_pkg::t_scan_st  o_st
);

    logic [efo_pkg::MASK_W-1:0] r_mask;
    logic [efo_pkg::TASK_W-1:0] r_tsk;
    logic                       r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_tsk   <= '0;
            r_first <= 1'b1;
        end else if (i_ctl.load) begin
            r_mask  <= i_ctl.mask;
            r_tsk   <= '0;
            r_first <= 1'b1;
        end else if (i_ctl.step) begin
            r_mask <= r_mask >> 1;
            r_tsk  <= r_tsk + efo_pkg::TASK_W'(1);
            if (r_mask[0]) begin
                r_first <= 1'b0;
            end
        end
    end

    assign o_st.hit   = r_mask[0];
    assign o_st.last  = (r_mask[efo_pkg::MASK_W-1:1] == '0);
    assign o_st.first = r_first;
    assign o_st.tsk   = r_tsk;

endmodule

// ===== rtl/core/event_subscriber_fanout.sv =====
// Top level of the publish/subscribe event fan-out block.
//
// Requests arrive on i_req (valid/ready). Kind 0 subscribes task_index to
// event_id, kind 1 unsubscribes it, kind 2 publishes to every subscribed task.
// Deliveries leave on o_dlv (valid/ready), one per subscribed task in
// ascending task order; is_last marks the final delivery of a publish.
// A request is taken only while the sequencer is idle. Subscribe and
// unsubscribe read the mask, then write it back. A publish reads the mask,
// then loads the scanner, which steps through the task positions up to the
// highest subscribed task; it examines one task bit per cycle while the
// delivery register is free or the bit is clear. The first delivery passes
// the mask read, the scanner load and the delivery register.
// A held delivery register separates the output: when the receiver stalls,
// the scanner holds on the next subscribed task until the register frees.
// Publishing to an empty mask gives no delivery and bumps dropped_total.
// Reset clears all subscriber masks at once (valid bits) and both counters;
// requests are taken from the first cycle after reset.
module event_subscriber_fanout (
    input  logic       i_clk,
    input  logic       i_rst_n,
    efo_req_if.sink    i_req,
    efo_dlv_if.source  o_dlv
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [efo_pkg::KIND_W-1:0]   r_kind;
    logic [efo_pkg::EV_W-1:0]     r_ev;
    logic [efo_pkg::TASK_W-1:0]   r_tsk;
    logic [efo_pkg::HANDLE_W-1:0] r_handle;
    logic [efo_pkg::SIZE_W-1:0]   r_size;
    logic                         r_zc;
    logic [efo_pkg::CNT_W-1:0]    r_pub_cnt;
    logic [efo_pkg::CNT_W-1:0]    r_drop_cnt;

    logic                         r_o_valid;
    logic [efo_pkg::TASK_W-1:0]   r_o_task;
    logic [efo_pkg::DEV_W-1:0]    r_o_event;
    logic [efo_pkg::HANDLE_W-1:0] r_o_payload;
    logic [efo_pkg::SIZE_W-1:0]   r_o_size;
    logic [efo_pkg::MODE_W-1:0]   r_o_mode;
    logic                         r_o_last;
    logic [efo_pkg::CNT_W-1:0]    r_o_pub;
    logic [efo_pkg::CNT_W-1:0]    r_o_drop;

    logic                         w_acc;
    logic                         w_ev_ok;
    logic                         w_task_ok;
    logic                         w_take;
    logic [efo_pkg::MASK_W-1:0]   w_mask;
    logic [efo_pkg::MASK_W-1:0]   w_bit;
    logic                         w_wr_en;
    logic [efo_pkg::MASK_W-1:0]   w_wr_data;
    logic                         w_is_pub;
    logic                         w_slot_free;
    logic                         w_emit;
    efo_pkg::t_scan_ctl           w_ctl;
    efo_pkg::t_scan_st            w_st;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_ev_ok     = ({1'b0, i_req.event_id} < efo_pkg::EV_LIMIT);
    assign w_task_ok   = ({1'b0, i_req.task_index} < efo_pkg::TASK_LIMIT);
    assign w_take      = w_acc && w_ev_ok &&
                         ((i_req.kind == efo_pkg::KIND_PUB) ||
                          (((i_req.kind == efo_pkg::KIND_SUB) ||
                            (i_req.kind == efo_pkg::KIND_UNSUB)) && w_task_ok));

    efo_mask_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_take),
        .i_rd_addr (i_req.event_id[efo_pkg::EV_AW-1:0]),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_ev[efo_pkg::EV_AW-1:0]),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_mask)
    );

    assign w_is_pub  = (r_kind == efo_pkg::KIND_PUB);
    assign w_bit     = efo_pkg::MASK_W'(1) << r_tsk;
    assign w_wr_en   = (r_state == S_READ) && !w_is_pub;
    assign w_wr_data = (r_kind == efo_pkg::KIND_SUB) ? (w_mask | w_bit) : (w_mask & ~w_bit);

    assign w_slot_free = !r_o_valid || o_dlv.ready;
    assign w_emit      = (r_state == S_SCAN) && w_st.hit && w_slot_free;

    assign w_ctl.load = (r_state == S_READ) && w_is_pub && (w_mask != '0);
    assign w_ctl.step = (r_state == S_SCAN) && (!w_st.hit || w_slot_free);
    assign w_ctl.mask = w_mask;

    efo_scan_unit u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_st    (w_st)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = w_ctl.load ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (w_ctl.step && w_st.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold the request fields for the read and scan phases
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind   <= i_req.kind;
            r_ev     <= i_req.event_id;
            r_tsk    <= i_req.task_index;
            r_handle <= i_req.payload_handle;
            r_size   <= i_req.payload_size;
            r_zc     <= i_req.single_handoff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pub_cnt  <= '0;
            r_drop_cnt <= '0;
        end else begin
            if (w_emit) begin
                r_pub_cnt <= r_pub_cnt + efo_pkg::CNT_W'(1);
            end
            if ((r_state == S_READ) && w_is_pub && (w_mask == '0)) begin
                r_drop_cnt <= r_drop_cnt + efo_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (o_dlv.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_task  <= w_st.tsk;
            r_o_event <= r_ev[efo_pkg::DEV_W-1:0];
            r_o_size  <= r_size;
            r_o_last  <= w_st.last;
            r_o_pub   <= r_pub_cnt + efo_pkg::CNT_W'(1);
            r_o_drop  <= r_drop_cnt;
            if (!r_zc) begin
                r_o_payload <= r_handle;
                r_o_mode    <= efo_pkg::MODE_COPY;
            end else if (w_st.first) begin
                r_o_payload <= r_handle;
                r_o_mode    <= efo_pkg::MODE_ORIGINAL;
            end else begin
                r_o_payload <= '0;
                r_o_mode    <= efo_pkg::MODE_NONE;
            end
        end
    end

    assign o_dlv.valid           = r_o_valid;
    assign o_dlv.target_task     = r_o_task;
    assign o_dlv.delivered_event = r_o_event;
    assign o_dlv.handed_payload  = r_o_payload;
    assign o_dlv.handed_size     = r_o_size;
    assign o_dlv.delivery_mode   = r_o_mode;
    assign o_dlv.is_last         = r_o_last;
    assign o_dlv.published_total = r_o_pub;
    assign o_dlv.dropped_total   = r_o_drop;

    // a new delivery never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_o_valid || o_dlv.ready))
        else $error("delivery register overwritten while stalled");

    // the delivery count moves by one per delivery
    a_pub_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_pub_cnt == $past(r_pub_cnt) + efo_pkg::CNT_W'(1)))
        else $error("published count out of step with deliveries");

    // drops are counted only at the end of a publish mask read
    a_drop_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drop_cnt != $past(r_drop_cnt)) |-> $past(r_state == S_READ))
        else $error("dropped count changed outside mask read");

    // a load of the scanner is always followed by the scan state
    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load |=> (r_state == S_SCAN))
        else $error("scanner loaded without entering scan");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the event fan-out block: queued requests, predicted deliveries.
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 80;
    localparam int HOT_EVENTS     = 6;
    localparam int NUM_PHASES     = 4;

    localparam logic [efo_pkg::KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 86, 0, 32};
    localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 86, 32};

    typedef struct packed {
        logic [efo_pkg::KIND_W-1:0]   kind;
        logic [efo_pkg::EV_W-1:0]     event_id;
        logic [efo_pkg::TASK_W-1:0]   task_index;
        logic [efo_pkg::HANDLE_W-1:0] payload_handle;
        logic [efo_pkg::SIZE_W-1:0]   payload_size;
        logic                         single_handoff;
    } t_req_item;

    typedef struct packed {
        logic [efo_pkg::TASK_W-1:0]   target_task;
        logic [efo_pkg::DEV_W-1:0]    delivered_event;
        logic [efo_pkg::HANDLE_W-1:0] handed_payload;
        logic [efo_pkg::SIZE_W-1:0]   handed_size;
        logic [efo_pkg::MODE_W-1:0]   delivery_mode;
        logic                         is_last;
        logic [efo_pkg::CNT_W-1:0]    published_total;
        logic [efo_pkg::CNT_W-1:0]    dropped_total;
    } t_delivery;

    logic i_clk;
    logic i_rst_n;

    efo_req_if req_if ();
    efo_dlv_if dlv_if ();

    event_subscriber_fanout u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_dlv   (dlv_if)
    );

    // Shadow copy of the block's state
    logic [efo_pkg::MASK_W-1:0] sub_table [efo_pkg::NUM_EVENTS];
    logic [efo_pkg::CNT_W-1:0]  delivery_count;
    logic [efo_pkg::CNT_W-1:0]  drop_count;

    t_req_item                  req_backlog[$];
    t_delivery                  delivery_expect[$];
    logic [efo_pkg::EV_W-1:0]   hot_events [HOT_EVENTS];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int quiet_cycles;
    int stim_counted;

    always #10 i_clk = ~i_clk;

    function automatic void predict_deliveries(t_req_item r);
        logic [efo_pkg::MASK_W-1:0] mask;
        int                         top;
        bit                         first;
        t_delivery                  d;
        top   = -1;
        first = 1'b1;
        if (r.event_id >= efo_pkg::NUM_EVENTS) return;
        if (r.kind == efo_pkg::KIND_SUB || r.kind == efo_pkg::KIND_UNSUB) begin
            if (r.task_index >= efo_pkg::NUM_TASKS) return;
            sub_table[r.event_id][r.task_index] = (r.kind == efo_pkg::KIND_SUB);
            return;
        end
        if (r.kind != efo_pkg::KIND_PUB) return;
        mask = sub_table[r.event_id];
        if (mask == '0) begin
            drop_count = drop_count + 1'b1;
            return;
        end
        for (int t = 0; t < efo_pkg::NUM_TASKS; t++) begin
            if (mask[t]) top = t;
        end
        for (int t = 0; t < efo_pkg::NUM_TASKS; t++) begin
            if (mask[t]) begin
                delivery_count    = delivery_count + 1'b1;
                d.target_task     = efo_pkg::TASK_W'(t);
                d.delivered_event = r.event_id[efo_pkg::DEV_W-1:0];
                if (r.single_handoff) begin
                    d.handed_payload = first ? r.payload_handle : '0;
                    d.delivery_mode  = first ? efo_pkg::MODE_ORIGINAL : efo_pkg::MODE_NONE;
                end else begin
                    d.handed_payload = r.payload_handle;
                    d.delivery_mode  = efo_pkg::MODE_COPY;
                end
                d.handed_size     = r.payload_size;
                d.is_last         = (t == top);
                d.published_total = delivery_count;
                d.dropped_total   = drop_count;
                delivery_expect.push_back(d);
                first = 1'b0;
            end
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic t_req_item random_req(logic [efo_pkg::KIND_W-1:0] kind, int ev, int tsk);
        t_req_item r;
        r.kind           = kind;
        r.event_id       = efo_pkg::EV_W'(ev);
        r.task_index     = efo_pkg::TASK_W'(tsk);
        r.payload_handle = $urandom;
        r.payload_size   = efo_pkg::SIZE_W'($urandom);
        r.single_handoff = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic queue_req(t_req_item r);
        req_backlog.push_back(r);
        if (r.event_id < efo_pkg::NUM_EVENTS && r.kind != KIND_UNKNOWN) stim_counted++;
    endtask

    task automatic push_op(logic [efo_pkg::KIND_W-1:0] kind, int ev, int tsk);
        queue_req(random_req(kind, ev, tsk));
    endtask

    task automatic queue_random_sequence();
        int pick;
        int ev;
        pick = $urandom_range(99);
        ev   = hot_events[$urandom_range(HOT_EVENTS - 1)];
        if (pick < 62) begin
            // subscribe a few, publish, sometimes thin the mask out again
            repeat ($urandom_range(1, 6))
                push_op(efo_pkg::KIND_SUB, ev, $urandom_range(efo_pkg::NUM_TASKS - 1));
            repeat ($urandom_range(1, 2))
                push_op(efo_pkg::KIND_PUB, ev, $urandom_range(efo_pkg::NUM_TASKS - 1));
            if ($urandom_range(1) == 1) begin
                repeat ($urandom_range(1, 4))
                    push_op(efo_pkg::KIND_UNSUB, ev, $urandom_range(efo_pkg::NUM_TASKS - 1));
            end
        end else if (pick < 65) begin
            // fill the whole mask
            for (int t = 0; t < efo_pkg::NUM_TASKS; t++) push_op(efo_pkg::KIND_SUB, ev, t);
            push_op(efo_pkg::KIND_PUB, ev, 0);
        end else if (pick < 68) begin
            // empty the whole mask, publish into nothing
            for (int t = 0; t < efo_pkg::NUM_TASKS; t++) push_op(efo_pkg::KIND_UNSUB, ev, t);
            push_op(efo_pkg::KIND_PUB, ev, 0);
        end else if (pick < 80) begin
            // mostly untouched events, so mostly drops
            push_op(efo_pkg::KIND_PUB, $urandom_range(efo_pkg::NUM_EVENTS - 1),
                    $urandom_range(efo_pkg::NUM_TASKS - 1));
        end else begin
            push_op(efo_pkg::KIND_W'($urandom_range(3)), $urandom_range(255),
                    $urandom_range(31));
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin
        t_req_item nxt;
        t_req_item took;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) begin
                took.kind           = req_if.kind;
                took.event_id       = req_if.event_id;
                took.task_index     = req_if.task_index;
                took.payload_handle = req_if.payload_handle;
                took.payload_size   = req_if.payload_size;
                took.single_handoff = req_if.single_handoff;
                predict_deliveries(took);
            end
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = req_backlog.pop_front();
                req_if.valid          <= 1'b1;
                req_if.kind           <= nxt.kind;
                req_if.event_id       <= nxt.event_id;
                req_if.task_index     <= nxt.task_index;
                req_if.payload_handle <= nxt.payload_handle;
                req_if.payload_size   <= nxt.payload_size;
                req_if.single_handoff <= nxt.single_handoff;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Delivery monitor
    always @(posedge i_clk) begin
        t_delivery got;
        t_delivery want;
        if (!i_rst_n) begin
            dlv_if.ready <= 1'b0;
        end else begin
            if (dlv_if.valid && dlv_if.ready) begin
                got.target_task     = dlv_if.target_task;
                got.delivered_event = dlv_if.delivered_event;
                got.handed_payload  = dlv_if.handed_payload;
                got.handed_size     = dlv_if.handed_size;
                got.delivery_mode   = dlv_if.delivery_mode;
                got.is_last         = dlv_if.is_last;
                got.published_total = dlv_if.published_total;
                got.dropped_total   = dlv_if.dropped_total;
                if (delivery_expect.size() == 0) begin
                    $display("%0t: unexpected delivery: expected none, actual %p", $time, got);
                    fail_count++;
                end else begin
                    want = delivery_expect.pop_front();
                    check_field("target_task", 32'(want.target_task), 32'(got.target_task));
                    check_field("delivered_event", 32'(want.delivered_event),
                                32'(got.delivered_event));
                    check_field("handed_payload", want.handed_payload, got.handed_payload);
                    check_field("handed_size", 32'(want.handed_size), 32'(got.handed_size));
                    check_field("delivery_mode", 32'(want.delivery_mode),
                                32'(got.delivery_mode));
                    check_field("is_last", 32'(want.is_last), 32'(got.is_last));
                    check_field("published_total", want.published_total, got.published_total);
                    check_field("dropped_total", want.dropped_total, got.dropped_total);
                end
            end
            dlv_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (dlv_if.valid && dlv_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, nothing moved for %0d cycles, %0d deliveries outstanding",
                     $time, WATCHDOG_LIMIT, delivery_expect.size());
            $display("event_subscriber_fanout regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_req_item r;
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.kind           = efo_pkg::KIND_SUB;
        req_if.event_id       = '0;
        req_if.task_index     = '0;
        req_if.payload_handle = '0;
        req_if.payload_size   = '0;
        req_if.single_handoff = 1'b0;
        dlv_if.ready          = 1'b0;
        send_idle_pct         = SEND_IDLE_PCT[0];
        recv_stall_pct        = RECV_STALL_PCT[0];
        fail_count            = 0;
        quiet_cycles          = 0;
        stim_counted          = 0;
        delivery_count        = '0;
        drop_count            = '0;
        foreach (sub_table[e]) sub_table[e] = '0;
        hot_events[0] = '0;
        hot_events[1] = efo_pkg::EV_W'(efo_pkg::NUM_EVENTS - 1);
        for (int h = 2; h < HOT_EVENTS; h++)
            hot_events[h] = efo_pkg::EV_W'($urandom_range(efo_pkg::NUM_EVENTS - 1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty mask, field extremes, both modes, ignored requests
        push_op(efo_pkg::KIND_PUB, 5, 0);
        push_op(efo_pkg::KIND_SUB, 0, 0);
        push_op(efo_pkg::KIND_SUB, 0, efo_pkg::NUM_TASKS - 1);
        r = random_req(efo_pkg::KIND_PUB, 0, 0);
        r.payload_handle = '1;
        r.payload_size   = '1;
        r.single_handoff = 1'b1;
        queue_req(r);
        r = random_req(efo_pkg::KIND_PUB, 0, 31);
        r.payload_handle = '0;
        r.payload_size   = '0;
        r.single_handoff = 1'b0;
        queue_req(r);
        push_op(efo_pkg::KIND_SUB, efo_pkg::NUM_EVENTS - 1, efo_pkg::NUM_TASKS - 1);
        r = random_req(efo_pkg::KIND_PUB, efo_pkg::NUM_EVENTS - 1, 0);
        r.single_handoff = 1'b1;
        queue_req(r);
        push_op(efo_pkg::KIND_SUB, 200, 3);
        push_op(efo_pkg::KIND_PUB, 255, 0);
        push_op(KIND_UNKNOWN, 0, 0);
        push_op(efo_pkg::KIND_UNSUB, 128, efo_pkg::NUM_TASKS - 1);
        push_op(efo_pkg::KIND_UNSUB, 0, 0);
        push_op(efo_pkg::KIND_UNSUB, 0, 5);
        push_op(efo_pkg::KIND_PUB, 0, 0);
        push_op(efo_pkg::KIND_UNSUB, 0, efo_pkg::NUM_TASKS - 1);
        push_op(efo_pkg::KIND_PUB, 0, 0);
        push_op(efo_pkg::KIND_SUB, 64, 1);
        push_op(efo_pkg::KIND_SUB, 64, 2);
        r = random_req(efo_pkg::KIND_PUB, 64, 0);
        r.single_handoff = 1'b1;
        queue_req(r);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            @(negedge i_clk);
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            stim_counted   = 0;
            while (stim_counted < PHASE_ITEMS) queue_random_sequence();
            while (req_backlog.size() != 0) @(negedge i_clk);
        end

        // Drain: everything sent, every delivery in, then watch for strays
        while (req_backlog.size() != 0 || req_if.valid || delivery_expect.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (delivery_expect.size() != 0) begin
            $display("%0t: %0d deliveries never arrived", $time, delivery_expect.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("event_subscriber_fanout regression: pass");
        end else begin
            $display("event_subscriber_fanout regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/efo_pkg.sv
rtl/core/efo_if.sv
rtl/core/efo_mask_table.sv
rtl/core/efo_scan_unit.sv
rtl/core/event_subscriber_fanout.sv
tb/sv/tb_top.sv
